// ===== hw/rtl/indexed_list_insert_delete_assert.svh =====
// Assertion macros shared by the indexed list design.
`ifndef INDEXED_LIST_INSERT_DELETE_ASSERT_SVH
`define INDEXED_LIST_INSERT_DELETE_ASSERT_SVH

// Same-cycle implication, sampled on clk_i and disabled while rst_ni is low.
`define ILI_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk_i and disabled while rst_ni is low.
`define ILI_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hw/rtl/ili_pkg.sv =====
// Types and constants of the indexed list with insert and delete.
package ili_pkg;

  localparam int unsigned CAPACITY = 64;
  localparam int unsigned IDX_W    = $clog2(CAPACITY);
  localparam int unsigned CNT_W    = $clog2(CAPACITY + 1);
  localparam int unsigned VAL_W    = 32;

  typedef enum logic [2:0] {
    OP_GET    = 3'd0,
    OP_SET    = 3'd1,
    OP_APPEND = 3'd2,
    OP_INSERT = 3'd3,
    OP_REMOVE = 3'd4,
    OP_FIND   = 3'd5,
    OP_CLEAR  = 3'd6
  } ili_op_e;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_RANGE   = 2'd1,
    ST_FULL    = 2'd2,
    ST_MISSING = 2'd3
  } ili_status_e;

  typedef struct packed {
    logic [2:0]         operation;
    logic [5:0]         index;
    logic signed [31:0] value;
  } ili_in_t;

  typedef struct packed {
    logic signed [31:0] read_value;
    logic [5:0]         position;
    logic [1:0]         status;
    logic [6:0]         length;
    logic signed [31:0] front_value;
    logic signed [31:0] back_value;
  } ili_out_t;

  typedef struct packed {
    logic             set;
    logic             app;
    logic             ins;
    logic             rem;
    logic             clr;
    logic [5:0]       idx;
    logic [VAL_W-1:0] value;
    logic [CNT_W-1:0] count;
  } ili_cell_ctrl_t;

endpackage

// ===== hw/rtl/ili_cell.sv =====
// One storage cell of the list: holds an element, shifts, writes and compares.
module ili_cell (
  input  logic                         clk_i,
  input  logic [ili_pkg::IDX_W-1:0]    pos_i,
  input  ili_pkg::ili_cell_ctrl_t      ctrl_i,
  input  logic [ili_pkg::VAL_W-1:0]    left_i,
  input  logic [ili_pkg::VAL_W-1:0]    right_i,
  output logic [ili_pkg::VAL_W-1:0]    elem_o,
  output logic                         match_o
);
  import ili_pkg::*;

  logic [VAL_W-1:0] elem_q, elem_d;
  logic             at_idx, past_idx, at_cnt, below_cnt;

  assign at_idx    = (32'(pos_i) == 32'(ctrl_i.idx));
  assign past_idx  = (32'(pos_i) >  32'(ctrl_i.idx));
  assign at_cnt    = (32'(pos_i) == 32'(ctrl_i.count));
  assign below_cnt = (32'(pos_i) <  32'(ctrl_i.count));

  always_comb begin
    elem_d = elem_q;
    if (ctrl_i.clr) begin
      elem_d = '0;
    end else if (ctrl_i.ins && past_idx) begin
      elem_d = left_i;
    end else if (ctrl_i.ins && at_idx) begin
      elem_d = ctrl_i.value;
    end else if (ctrl_i.rem && (past_idx || at_idx)) begin
      elem_d = right_i;
    end else if (ctrl_i.set && at_idx) begin
      elem_d = ctrl_i.value;
    end else if (ctrl_i.app && at_cnt) begin
      elem_d = ctrl_i.value;
    end
  end

  always_ff @(posedge clk_i) begin
    elem_q <= elem_d;
  end

  assign elem_o  = elem_q;
  assign match_o = below_cnt && (elem_q == ctrl_i.value);

endmodule

// ===== hw/rtl/indexed_list_insert_delete.sv =====
// Indexed list of signed 32-bit values with get, set, append, insert, remove, find and clear.
// Each item passes through these steps from its transfer to its result: the command is registered,
// then every cell of the row shifts, writes or compares at once while the selected or first
// matching element is captured, and then the front and back of the updated row are picked into
// the output register, waiting while the output stalls. No new item is taken until the last one
// is reported; the result register frees the input side, so the next item is accepted while a
// result still waits. No clearing pass follows reset.
module indexed_list_insert_delete (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  ili_pkg::ili_in_t      in_data_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output ili_pkg::ili_out_t     out_data_o,
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [6:0]            cfg_data_i
);
  import ili_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE   = 3'b001,
    S_EXEC   = 3'b010,
    S_REPORT = 3'b100
  } state_e;

  state_e           state_q, state_d;
  ili_in_t          cmd_q;
  logic [CNT_W-1:0] count_q, count_d, clr_cnt;
  logic [6:0]       start_len_q;
  logic [VAL_W-1:0] res_rd_q, res_rd_d;
  logic [5:0]       res_pos_q, res_pos_d;
  ili_status_e      res_st_q, res_st_d;
  ili_out_t         out_q;
  logic             out_valid_q;

  ili_cell_ctrl_t   ctrl;
  logic             set_c, app_c, ins_c, rem_c, clr_c;
  logic             exec, in_range, full, found, out_free;
  logic [5:0]       found_pos;
  logic [VAL_W-1:0] sel_idx, sel_back;
  logic [VAL_W-1:0] elem [CAPACITY];
  logic [VAL_W-1:0] right_in [CAPACITY];
  logic [VAL_W-1:0] left_in [CAPACITY];
  logic [CAPACITY-1:0] match;

  assign exec     = (state_q == S_EXEC);
  assign in_range = (32'(cmd_q.index) < 32'(count_q));
  assign full     = (32'(count_q) >= 32'(CAPACITY));
  assign clr_cnt  = (32'(start_len_q) > 32'(CAPACITY)) ? CNT_W'(CAPACITY)
                                                       : CNT_W'(start_len_q);

  assign ctrl.set   = set_c & exec;
  assign ctrl.app   = app_c & exec;
  assign ctrl.ins   = ins_c & exec;
  assign ctrl.rem   = rem_c & exec;
  assign ctrl.clr   = clr_c & exec;
  assign ctrl.idx   = cmd_q.index;
  assign ctrl.value = cmd_q.value;
  assign ctrl.count = count_q;

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    if (i == 0) begin : g_first
      assign left_in[i] = '0;
    end else begin : g_mid
      assign left_in[i] = elem[i-1];
    end
    if (i == CAPACITY - 1) begin : g_last
      assign right_in[i] = '0;
    end else begin : g_body
      assign right_in[i] = elem[i+1];
    end
    ili_cell u_cell (
      .clk_i   (clk_i),
      .pos_i   (IDX_W'(i)),
      .ctrl_i  (ctrl),
      .left_i  (left_in[i]),
      .right_i (right_in[i]),
      .elem_o  (elem[i]),
      .match_o (match[i])
    );
  end

  always_comb begin
    sel_idx   = '0;
    sel_back  = '0;
    found     = 1'b0;
    found_pos = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      if (32'(i) == 32'(cmd_q.index)) begin
        sel_idx = sel_idx | elem[i];
      end
      if (32'(i) + 32'd1 == 32'(count_q)) begin
        sel_back = sel_back | elem[i];
      end
    end
    for (int i = CAPACITY - 1; i >= 0; i--) begin
      if (match[i]) begin
        found     = 1'b1;
        found_pos = 6'(i);
      end
    end
  end

  always_comb begin
    res_rd_d  = '0;
    res_pos_d = '0;
    res_st_d  = ST_OK;
    count_d   = count_q;
    set_c     = 1'b0;
    app_c     = 1'b0;
    ins_c     = 1'b0;
    rem_c     = 1'b0;
    clr_c     = 1'b0;
    case (cmd_q.operation)
      OP_GET: begin
        if (in_range) res_rd_d = sel_idx;
        else res_st_d = ST_RANGE;
      end
      OP_SET: begin
        if (in_range) set_c = 1'b1;
        else res_st_d = ST_RANGE;
      end
      OP_APPEND: begin
        if (full) begin
          res_st_d = ST_FULL;
        end else begin
          app_c   = 1'b1;
          count_d = count_q + CNT_W'(1);
        end
      end
      OP_INSERT: begin
        if (!in_range) begin
          res_st_d = ST_RANGE;
        end else if (full) begin
          res_st_d = ST_FULL;
        end else begin
          ins_c   = 1'b1;
          count_d = count_q + CNT_W'(1);
        end
      end
      OP_REMOVE: begin
        if (!in_range) begin
          res_st_d = ST_RANGE;
        end else begin
          res_rd_d = sel_idx;
          rem_c    = 1'b1;
          count_d  = count_q - CNT_W'(1);
        end
      end
      OP_FIND: begin
        if (found) res_pos_d = found_pos;
        else res_st_d = ST_MISSING;
      end
      OP_CLEAR: begin
        clr_c   = 1'b1;
        count_d = clr_cnt;
      end
      default: begin
      end
    endcase
  end

  assign out_free = !out_valid_q || !out_stall_i;

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE:   if (in_valid_i) state_d = S_EXEC;
      S_EXEC:   state_d = S_REPORT;
      S_REPORT: if (out_free) state_d = S_IDLE;
      default:  state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      start_len_q <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (exec) count_q <= count_d;
      if (cfg_valid_i && cfg_ready_o) start_len_q <= cfg_data_i;
      if (state_q == S_REPORT && out_free) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == S_IDLE && in_valid_i) cmd_q <= in_data_i;
    if (exec) begin
      res_rd_q  <= res_rd_d;
      res_pos_q <= res_pos_d;
      res_st_q  <= res_st_d;
    end
    if (state_q == S_REPORT && out_free) begin
      out_q.read_value  <= res_rd_q;
      out_q.position    <= res_pos_q;
      out_q.status      <= res_st_q;
      out_q.length      <= 7'(count_q);
      out_q.front_value <= (count_q != '0) ? elem[0] : '0;
      out_q.back_value  <= (count_q != '0) ? sel_back : '0;
    end
  end

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;
  assign cfg_ready_o = 1'b1;

`include "indexed_list_insert_delete_assert.svh"

  `ILI_ASSERT_NOW(a_count_bound, 1'b1, 32'(count_q) <= 32'(CAPACITY), "length above capacity")
  `ILI_ASSERT_NEXT(a_accept_exec, in_valid_i && !in_stall_o, state_q == S_EXEC, "transfer not executed")
  `ILI_ASSERT_NOW(a_empty_ends, out_valid_o && out_data_o.length == 7'd0, out_data_o.front_value == 32'sd0 && out_data_o.back_value == 32'sd0, "empty list with nonzero ends")

endmodule

// ===== tb/sv/tb_top.sv =====
// Self-checking testbench for the indexed list with insert and delete.
`timescale 1ns / 1ps

module tb_top;
  import ili_pkg::*;

  localparam logic [2:0] OP_UNUSED = 3'd7;
  localparam int unsigned DRAIN_CYCLES = 8;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  ili_in_t in_data_i = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  ili_out_t out_data_o;
  logic cfg_valid_i = 1'b0;
  logic cfg_ready_o;
  logic [6:0] cfg_data_i = '0;

  logic steady_mode = 1'b0;
  int unsigned fail_count = 0;

  logic [31:0] store_mem [CAPACITY];
  int unsigned list_len = 0;
  logic [6:0] clear_len = '0;
  ili_out_t expected_q [$];

  indexed_list_insert_delete dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_data_i  (cfg_data_i)
  );

  always #2 clk_i = ~clk_i;

  initial begin
    #2000000;
    $display("** indexed_list_insert_delete: FAILED **");
    $finish;
  end

  function automatic ili_out_t list_apply(input ili_in_t cmd);
    ili_out_t res;
    logic in_range;
    logic found;
    int unsigned p;
    res = '0;
    found = 1'b0;
    in_range = cmd.index < list_len;
    case (cmd.operation)
      OP_GET: begin
        if (in_range) res.read_value = store_mem[cmd.index];
        else res.status = ST_RANGE;
      end
      OP_SET: begin
        if (in_range) store_mem[cmd.index] = cmd.value;
        else res.status = ST_RANGE;
      end
      OP_APPEND: begin
        if (list_len >= CAPACITY) begin
          res.status = ST_FULL;
        end else begin
          store_mem[list_len] = cmd.value;
          list_len++;
        end
      end
      OP_INSERT: begin
        if (!in_range) begin
          res.status = ST_RANGE;
        end else if (list_len >= CAPACITY) begin
          res.status = ST_FULL;
        end else begin
          for (p = list_len; p > cmd.index; p--) store_mem[p] = store_mem[p - 1];
          store_mem[cmd.index] = cmd.value;
          list_len++;
        end
      end
      OP_REMOVE: begin
        if (!in_range) begin
          res.status = ST_RANGE;
        end else begin
          res.read_value = store_mem[cmd.index];
          for (p = cmd.index + 1; p < list_len; p++) store_mem[p - 1] = store_mem[p];
          list_len--;
        end
      end
      OP_FIND: begin
        res.status = ST_MISSING;
        for (p = 0; p < list_len; p++) begin
          if (!found && store_mem[p] == cmd.value) begin
            found = 1'b1;
            res.position = p[5:0];
            res.status = ST_OK;
          end
        end
      end
      OP_CLEAR: begin
        for (p = 0; p < CAPACITY; p++) store_mem[p] = '0;
        list_len = (clear_len > CAPACITY) ? CAPACITY : clear_len;
      end
      default: begin
      end
    endcase
    res.length = list_len[6:0];
    res.front_value = (list_len > 0) ? store_mem[0] : '0;
    res.back_value = (list_len > 0) ? store_mem[list_len - 1] : '0;
    return res;
  endfunction

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (want !== got) begin
      fail_count++;
      $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
    end
  endtask

  always @(posedge clk_i) begin
    ili_out_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_q.size() == 0) begin
        fail_count++;
        $display("%0t: unexpected result, expected none, actual %h", $time, out_data_o);
      end else begin
        want = expected_q.pop_front();
        check_field("read_value", want.read_value, out_data_o.read_value);
        check_field("position", 32'(want.position), 32'(out_data_o.position));
        check_field("status", 32'(want.status), 32'(out_data_o.status));
        check_field("length", 32'(want.length), 32'(out_data_o.length));
        check_field("front_value", want.front_value, out_data_o.front_value);
        check_field("back_value", want.back_value, out_data_o.back_value);
      end
    end
  end

  always @(negedge clk_i) begin
    out_stall_i = rst_ni && !steady_mode && ($urandom_range(0, 99) < 32);
  end

  task automatic send_item(input logic [2:0] op, input logic [5:0] idx,
                           input logic [31:0] val);
    ili_in_t cmd;
    ili_out_t predicted;
    cmd.operation = op;
    cmd.index = idx;
    cmd.value = val;
    @(negedge clk_i);
    while (!steady_mode && $urandom_range(0, 99) < 32) begin
      in_valid_i = 1'b0;
      @(negedge clk_i);
    end
    in_valid_i = 1'b1;
    in_data_i = cmd;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    predicted = list_apply(cmd);
    expected_q = {expected_q, predicted};
  endtask

  task automatic drain_results();
    @(negedge clk_i);
    in_valid_i = 1'b0;
    while (expected_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_start_length(input logic [6:0] len);
    drain_results();
    @(negedge clk_i);
    cfg_valid_i = 1'b1;
    cfg_data_i = len;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    clear_len = len;
    @(negedge clk_i);
    cfg_valid_i = 1'b0;
  endtask

  task automatic test_empty_list();
    send_item(OP_GET, 6'd0, 32'd0);
    send_item(OP_SET, 6'd0, 32'hDEADBEEF);
    send_item(OP_INSERT, 6'd0, 32'd5);
    send_item(OP_REMOVE, 6'd63, 32'd0);
    send_item(OP_FIND, 6'd0, 32'd0);
    send_item(OP_UNUSED, 6'd63, 32'hFFFFFFFF);
  endtask

  task automatic test_edit_ops();
    send_item(OP_APPEND, 6'd0, 32'h7FFFFFFF);
    send_item(OP_APPEND, 6'd63, 32'h80000000);
    send_item(OP_APPEND, 6'd0, 32'hFFFFFFFF);
    send_item(OP_INSERT, 6'd0, 32'd5);
    send_item(OP_INSERT, 6'd3, 32'd9);
    send_item(OP_INSERT, 6'd5, 32'd1);
    send_item(OP_GET, 6'd3, 32'd0);
    send_item(OP_SET, 6'd1, 32'hFFFFFFFF);
    send_item(OP_FIND, 6'd0, 32'hFFFFFFFF);
    send_item(OP_FIND, 6'd0, 32'h12345678);
    send_item(OP_REMOVE, 6'd0, 32'd0);
    send_item(OP_REMOVE, 6'd3, 32'd0);
    send_item(OP_GET, 6'd4, 32'd0);
    send_item(OP_UNUSED, 6'd1, 32'd7);
    send_item(OP_CLEAR, 6'd0, 32'd0);
    send_item(OP_GET, 6'd0, 32'd0);
  endtask

  task automatic test_full_array();
    write_start_length(7'd64);
    send_item(OP_CLEAR, 6'd0, 32'd0);
    send_item(OP_APPEND, 6'd0, 32'd3);
    send_item(OP_INSERT, 6'd0, 32'd3);
    send_item(OP_INSERT, 6'd63, 32'd3);
    send_item(OP_SET, 6'd63, 32'h80000000);
    send_item(OP_FIND, 6'd0, 32'h80000000);
    send_item(OP_FIND, 6'd0, 32'd0);
    send_item(OP_REMOVE, 6'd63, 32'd0);
    send_item(OP_APPEND, 6'd0, 32'h7FFFFFFF);
    send_item(OP_GET, 6'd63, 32'd0);
  endtask

  task automatic test_start_length();
    write_start_length(7'd127);
    send_item(OP_CLEAR, 6'd0, 32'd0);
    send_item(OP_GET, 6'd63, 32'd0);
    write_start_length(7'd65);
    send_item(OP_CLEAR, 6'd0, 32'd0);
    write_start_length(7'd1);
    send_item(OP_CLEAR, 6'd0, 32'd0);
    send_item(OP_GET, 6'd1, 32'd0);
    write_start_length(7'd0);
    send_item(OP_CLEAR, 6'd0, 32'd0);
  endtask

  task automatic send_random_item();
    int unsigned pick;
    logic [2:0] op;
    logic [5:0] idx;
    logic [31:0] val;
    pick = $urandom_range(0, 99);
    if (pick < 12) op = OP_GET;
    else if (pick < 24) op = OP_SET;
    else if (pick < 42) op = OP_APPEND;
    else if (pick < 58) op = OP_INSERT;
    else if (pick < 74) op = OP_REMOVE;
    else if (pick < 90) op = OP_FIND;
    else if (pick < 93) op = OP_CLEAR;
    else if (pick < 95) op = OP_UNUSED;
    else op = 3'($urandom_range(0, 7));
    if (list_len > 0 && $urandom_range(0, 99) < 85)
      idx = 6'($urandom_range(0, list_len - 1));
    else
      idx = 6'($urandom_range(0, 63));
    pick = $urandom_range(0, 99);
    if (op == OP_FIND && list_len > 0 && pick < 60)
      val = store_mem[$urandom_range(0, list_len - 1)];
    else if (pick < 60) val = $urandom;
    else if (pick < 85) val = 32'($urandom_range(0, 7));
    else if (pick < 90) val = 32'h80000000;
    else if (pick < 95) val = 32'h7FFFFFFF;
    else val = 32'hFFFFFFFF;
    send_item(op, idx, val);
  endtask

  task automatic test_random_mix();
    logic [6:0] phase_len [8];
    int unsigned ph;
    int unsigned n;
    phase_len = '{7'd0, 7'd64, 7'd127, 7'd1, 7'd33, 7'd65, 7'd0, 7'd0};
    phase_len[6] = 7'($urandom_range(0, 127));
    phase_len[7] = 7'($urandom_range(0, 64));
    for (ph = 0; ph < 8; ph++) begin
      write_start_length(phase_len[ph]);
      steady_mode = (ph == 2);
      send_item(OP_CLEAR, 6'd0, 32'd0);
      for (n = 0; n < 240; n++) send_random_item();
      steady_mode = 1'b0;
    end
  endtask

  initial begin
    foreach (store_mem[i]) store_mem[i] = '0;
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    test_empty_list();
    test_edit_ops();
    test_full_array();
    test_start_length();
    test_random_mix();
    drain_results();
    if (fail_count == 0)
      $display("** indexed_list_insert_delete: PASSED **");
    else
      $display("** indexed_list_insert_delete: FAILED **");
    $finish;
  end

endmodule
